### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the fractal noise block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SNF_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SNF_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/core/snf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snf_pkg
// Shared constants, types and helpers of the fractal simplex noise block.
// ----------------------------------------------------------------------------
package snf_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int TABLE_AW        = 8;
    localparam int MAX_OCTAVES     = 8;
    localparam int OCT_W           = 4;
    localparam int COORD_W         = 32;
    localparam int DX_W            = 24;
    localparam int AMP_W           = 17;
    localparam int FREQ_W          = 28;
    localparam int NORM_W          = 16;
    localparam int SUM_W           = 20;
    localparam int ACC_W           = 44;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 2;

    localparam logic [AMP_W-1:0]  AMP_ONE    = 17'd65536;
    localparam logic [FREQ_W-1:0] FREQ_ONE   = 28'd4096;
    localparam logic [FREQ_W-1:0] FREQ_MAX   = 28'hFFFFFFF;
    localparam logic [NORM_W-1:0] NORM_RESET = 16'd32768;

    localparam logic signed [15:0]     SKEW_Q16    = 16'sd23987;
    localparam logic signed [15:0]     UNSKEW_Q16  = 16'sd13849;
    localparam logic signed [DX_W-1:0] ONE_Q       = 24'sd65536;
    localparam logic signed [DX_W-1:0] G2_Q        = 24'sd13849;
    localparam logic signed [DX_W-1:0] G2X2_Q      = 24'sd27698;
    localparam logic signed [22:0]     NOISE_SCALE = 23'sd70;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OCTAVES = 2'd0,
        CFG_PERSIST = 2'd1,
        CFG_LACUN   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic idle;
        logic result_valid;
    } core_status_t;

    typedef struct packed {
        logic [TABLE_AW-1:0] perm_addr;
        logic [TABLE_AW-1:0] mod_addr;
    } rd_req_t;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [OCT_W-1:0] clamp_octaves(input logic [OCT_W-1:0] n);
        logic [OCT_W-1:0] r;
        r = n;
        if (n == '0)
            r = OCT_W'(1);
        else if (n > OCT_W'(MAX_OCTAVES))
            r = OCT_W'(MAX_OCTAVES);
        return r;
    endfunction

endpackage

### rtl/core/snf_perm_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snf_perm_mem
// Permutation table and its mod-12 copy, one write and one read port each.
// ----------------------------------------------------------------------------
module snf_perm_mem (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [snf_pkg::TABLE_AW-1:0]  wr_addr,
    input  logic [7:0]                    wr_value,
    input  snf_pkg::rd_req_t              rd_req,
    output logic [7:0]                    perm_data,
    output logic [3:0]                    mod_data
);

    localparam int DEPTH = 1 << snf_pkg::TABLE_AW;

    logic [7:0] perm_mem [DEPTH];
    logic [3:0] mod_mem  [DEPTH];
    logic [7:0] perm_data_reg;
    logic [3:0] mod_data_reg;
    logic [3:0] wr_mod12;
    logic [18:0] q_prod;
    logic [7:0]  q_val;
    logic [7:0]  r_val;

    // v mod 12 via reciprocal 171/2048, exact for 8-bit values
    always_comb
    begin
        q_prod   = {11'd0, wr_value} * 19'd171;
        q_val    = q_prod[18:11];
        r_val    = wr_value - 8'(q_val * 8'd12);
        wr_mod12 = r_val[3:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            perm_mem[wr_addr] <= wr_value;
            mod_mem[wr_addr]  <= wr_mod12;
        end
        perm_data_reg <= perm_mem[rd_req.perm_addr];
        mod_data_reg  <= mod_mem[rd_req.mod_addr];
    end

    assign perm_data = perm_data_reg;
    assign mod_data  = mod_data_reg;

endmodule

### rtl/core/snf_norm_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snf_norm_unit
// Sums octave amplitudes and divides 2^31 by the total, one bit per cycle.
// ----------------------------------------------------------------------------
module snf_norm_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [snf_pkg::OCT_W-1:0]   octave_count,
    input  logic [snf_pkg::CFG_W-1:0]   persistence,
    output logic                        busy,
    output logic [snf_pkg::NORM_W-1:0]  norm_recip
);

    typedef enum logic [2:0] {
        N_IDLE = 3'b001,
        N_SUM  = 3'b010,
        N_DIV  = 3'b100
    } nstate_t;

    nstate_t                      state_reg, state_next;
    logic [snf_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [snf_pkg::AMP_W-1:0]    amp_reg, amp_next;
    logic [4:0]                   cnt_reg, cnt_next;
    logic [snf_pkg::SUM_W-1:0]    rem_reg, rem_next;
    logic [snf_pkg::NORM_W-1:0]   quo_reg, quo_next;
    logic [snf_pkg::NORM_W-1:0]   norm_reg, norm_next;
    logic [snf_pkg::OCT_W-1:0]    n_oct;
    logic [32:0]                  amp_prod;
    logic [snf_pkg::SUM_W:0]      rem_shift;
    logic [snf_pkg::SUM_W:0]      rem_diff;
    logic                         q_bit;

    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        amp_next   = amp_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        norm_next  = norm_reg;

        n_oct     = snf_pkg::clamp_octaves(octave_count);
        amp_prod  = {16'd0, amp_reg} * {17'd0, persistence};
        // dividend is 2^31: a one on the first step, zeros after
        rem_shift = {rem_reg, (cnt_reg == 5'd0)};
        rem_diff  = rem_shift - {1'b0, sum_reg};
        q_bit     = (rem_shift >= {1'b0, sum_reg});

        case (state_reg)
            N_IDLE:
            begin
            end
            N_SUM:
            begin
                sum_next = sum_reg + snf_pkg::SUM_W'(amp_reg);
                amp_next = amp_prod[32:16];
                cnt_next = cnt_reg + 5'd1;
                if ((cnt_reg + 5'd1) == {1'b0, n_oct})
                begin
                    state_next = N_DIV;
                    cnt_next   = 5'd0;
                    rem_next   = '0;
                end
            end
            N_DIV:
            begin
                rem_next = q_bit ? rem_diff[snf_pkg::SUM_W-1:0]
                                 : rem_shift[snf_pkg::SUM_W-1:0];
                quo_next = {quo_reg[snf_pkg::NORM_W-2:0], q_bit};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    norm_next  = {quo_reg[snf_pkg::NORM_W-2:0], q_bit};
                    state_next = N_IDLE;
                end
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase

        if (start)
        begin
            state_next = N_SUM;
            sum_next   = '0;
            amp_next   = snf_pkg::AMP_ONE;
            cnt_next   = 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            norm_reg  <= snf_pkg::NORM_RESET;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            norm_reg  <= norm_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        amp_reg <= amp_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy       = (state_reg != N_IDLE);
    assign norm_recip = norm_reg;

endmodule

### rtl/core/snf_octave_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snf_octave_core
// Sequencer for one evaluation: per octave it scales the point, skews, hashes
// three corners through the table memories and accumulates the falloff terms.
// ----------------------------------------------------------------------------
module snf_octave_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [snf_pkg::COORD_W-1:0]  x_coord,
    input  logic signed [snf_pkg::COORD_W-1:0]  y_coord,
    input  logic [snf_pkg::OCT_W-1:0]           octave_count,
    input  logic [snf_pkg::CFG_W-1:0]           persistence,
    input  logic [snf_pkg::CFG_W-1:0]           lacunarity,
    input  logic [snf_pkg::NORM_W-1:0]          norm_recip,
    input  logic                                out_free,
    output snf_pkg::rd_req_t                    rd_req,
    input  logic [7:0]                          perm_data,
    input  logic [3:0]                          mod_data,
    output snf_pkg::core_status_t               status,
    output logic signed [15:0]                  result
);

    localparam int DW = snf_pkg::DX_W;
    localparam int F  = snf_pkg::COORD_FRAC_BITS;

    typedef enum logic [19:0] {
        ST_IDLE    = 20'h00001,
        ST_SCALE_X = 20'h00002,
        ST_SCALE_Y = 20'h00004,
        ST_SKEW    = 20'h00008,
        ST_CELL    = 20'h00010,
        ST_UNSKEW  = 20'h00020,
        ST_OFFS    = 20'h00040,
        ST_HASH1   = 20'h00080,
        ST_HASH2   = 20'h00100,
        ST_HASH3   = 20'h00200,
        ST_SQX     = 20'h00400,
        ST_SQY     = 20'h00800,
        ST_POW2    = 20'h01000,
        ST_POW4    = 20'h02000,
        ST_DOT     = 20'h04000,
        ST_NOISE   = 20'h08000,
        ST_ACC     = 20'h10000,
        ST_AMP     = 20'h20000,
        ST_NORM    = 20'h40000,
        ST_DONE    = 20'h80000
    } cstate_t;

    cstate_t                            state_reg, state_next;
    logic signed [31:0]                 x_reg, x_next, y_reg, y_next;
    logic [snf_pkg::OCT_W-1:0]          n_reg, n_next, k_reg, k_next;
    logic [snf_pkg::AMP_W-1:0]          amp_reg, amp_next;
    logic [snf_pkg::FREQ_W-1:0]         freq_reg, freq_next;
    logic signed [snf_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic signed [31:0]                 xs_reg, xs_next, ys_reg, ys_next;
    logic signed [31:0]                 s_reg, s_next;
    logic signed [17:0]                 i_reg, i_next, j_reg, j_next;
    logic signed [DW-1:0]               cx_reg [3];
    logic signed [DW-1:0]               cx_next [3];
    logic signed [DW-1:0]               cy_reg [3];
    logic signed [DW-1:0]               cy_next [3];
    logic [3:0]                         ch_reg [3];
    logic [3:0]                         ch_next [3];
    logic                               i1_reg, i1_next;
    logic [1:0]                         c_reg, c_next;
    logic signed [2*DW-1:0]             sqx_reg, sqx_next;
    logic [15:0]                        t_reg, t_next;
    logic signed [15:0]                 sum_reg, sum_next;
    logic signed [22:0]                 noise_reg, noise_next;
    logic signed [15:0]                 res_reg, res_next;

    logic signed [31:0]                 scale_src;
    logic signed [60:0]                 scale_prod;
    logic signed [60:0]                 scale_sh;
    logic signed [31:0]                 scale_sat;
    logic signed [32:0]                 sxy;
    logic signed [48:0]                 skew_prod;
    logic signed [48:0]                 skew_sh;
    logic signed [33:0]                 xsum, ysum;
    logic signed [33:0]                 xsum_sh, ysum_sh;
    logic signed [18:0]                 ij;
    logic signed [34:0]                 unskew_t;
    logic signed [35:0]                 x0_full, y0_full;
    logic                               i1_cmp;
    logic signed [DW-1:0]               dx, dy;
    logic [3:0]                         gh;
    logic signed [2*DW-1:0]             sq_prod;
    logic signed [49:0]                 falloff;
    logic [31:0]                        pow_prod;
    logic signed [25:0]                 dot_x, dot_y, dot;
    logic signed [42:0]                 dot_prod;
    logic signed [42:0]                 dot_sh;
    logic signed [40:0]                 acc_prod;
    logic [32:0]                        amp_prod;
    logic [43:0]                        freq_prod;
    logic [31:0]                        freq_sh;
    logic signed [60:0]                 norm_prod;
    logic signed [60:0]                 norm_sh;
    logic [7:0]                         ii, jj;

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        amp_next   = amp_reg;
        freq_next  = freq_reg;
        acc_next   = acc_reg;
        xs_next    = xs_reg;
        ys_next    = ys_reg;
        s_next     = s_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        ch_next    = ch_reg;
        i1_next    = i1_reg;
        c_next     = c_reg;
        sqx_next   = sqx_reg;
        t_next     = t_reg;
        sum_next   = sum_reg;
        noise_next = noise_reg;
        res_next   = res_reg;

        ii = i_reg[7:0];
        jj = j_reg[7:0];
        rd_req.perm_addr = jj;
        rd_req.mod_addr  = ii;
        status.idle         = (state_reg == ST_IDLE);
        status.result_valid = 1'b0;

        // point scaling, shared between x and y
        scale_src  = (state_reg == ST_SCALE_Y) ? y_reg : x_reg;
        scale_prod = 61'(scale_src) * $signed({33'd0, freq_reg});
        scale_sh   = scale_prod >>> 12;
        if (scale_sh > 61'sd2147483647)
            scale_sat = 32'sh7FFFFFFF;
        else if (scale_sh < -61'sd2147483648)
            scale_sat = 32'sh80000000;
        else
            scale_sat = scale_sh[31:0];

        sxy       = 33'(xs_reg) + 33'(ys_reg);
        skew_prod = 49'(sxy) * 49'(snf_pkg::SKEW_Q16);
        skew_sh   = skew_prod >>> 16;

        xsum    = 34'(xs_reg) + 34'(s_reg);
        ysum    = 34'(ys_reg) + 34'(s_reg);
        xsum_sh = xsum >>> F;
        ysum_sh = ysum >>> F;

        ij       = 19'(i_reg) + 19'(j_reg);
        unskew_t = 35'(ij) * 35'(snf_pkg::UNSKEW_Q16);
        x0_full  = 36'(xs_reg) - (36'(i_reg) <<< F) + 36'(unskew_t);
        y0_full  = 36'(ys_reg) - (36'(j_reg) <<< F) + 36'(unskew_t);

        i1_cmp = (cx_reg[0] > cy_reg[0]);

        dx      = cx_reg[c_reg];
        dy      = cy_reg[c_reg];
        gh      = ch_reg[c_reg];
        sq_prod = 48'(dx) * 48'(dy);
        if (state_reg == ST_SQX)
            sq_prod = 48'(dx) * 48'(dx);
        else
            sq_prod = 48'(dy) * 48'(dy);
        falloff  = (50'sd1 <<< (2 * F - 1)) - 50'(sqx_reg) - 50'(sq_prod);
        pow_prod = {16'd0, t_reg} * {16'd0, t_reg};

        // gradient set: x is +-1 for codes below 8, y is +-1 below 4 and 8..11
        if (gh < 4'd8)
            dot_x = gh[0] ? -26'(dx) : 26'(dx);
        else
            dot_x = '0;
        if (gh < 4'd4)
            dot_y = gh[1] ? -26'(dy) : 26'(dy);
        else if (gh < 4'd8)
            dot_y = '0;
        else if (gh < 4'd12)
            dot_y = gh[0] ? -26'(dy) : 26'(dy);
        else
            dot_y = '0;
        dot      = dot_x + dot_y;
        dot_prod = 43'($signed({1'b0, t_reg})) * 43'(dot);
        dot_sh   = dot_prod >>> F;

        acc_prod  = 41'(noise_reg) * $signed({24'd0, amp_reg});
        amp_prod  = {16'd0, amp_reg} * {17'd0, persistence};
        freq_prod = {16'd0, freq_reg} * {28'd0, lacunarity};
        freq_sh   = freq_prod[43:12];

        norm_prod = 61'(acc_reg) * $signed({45'd0, norm_recip});
        norm_sh   = norm_prod >>> (F + 16);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    x_next     = x_coord;
                    y_next     = y_coord;
                    n_next     = snf_pkg::clamp_octaves(octave_count);
                    k_next     = '0;
                    amp_next   = snf_pkg::AMP_ONE;
                    freq_next  = snf_pkg::FREQ_ONE;
                    acc_next   = '0;
                    state_next = ST_SCALE_X;
                end
            end
            ST_SCALE_X:
            begin
                xs_next    = scale_sat;
                state_next = ST_SCALE_Y;
            end
            ST_SCALE_Y:
            begin
                ys_next    = scale_sat;
                state_next = ST_SKEW;
            end
            ST_SKEW:
            begin
                s_next     = skew_sh[31:0];
                state_next = ST_CELL;
            end
            ST_CELL:
            begin
                i_next     = xsum_sh[17:0];
                j_next     = ysum_sh[17:0];
                state_next = ST_UNSKEW;
            end
            ST_UNSKEW:
            begin
                cx_next[0]       = x0_full[DW-1:0];
                cy_next[0]       = y0_full[DW-1:0];
                rd_req.perm_addr = jj;
                state_next       = ST_OFFS;
            end
            ST_OFFS:
            begin
                i1_next    = i1_cmp;
                cx_next[1] = cx_reg[0] - (i1_cmp ? snf_pkg::ONE_Q : '0) + snf_pkg::G2_Q;
                cy_next[1] = cy_reg[0] - (i1_cmp ? '0 : snf_pkg::ONE_Q) + snf_pkg::G2_Q;
                cx_next[2] = cx_reg[0] - snf_pkg::ONE_Q + snf_pkg::G2X2_Q;
                cy_next[2] = cy_reg[0] - snf_pkg::ONE_Q + snf_pkg::G2X2_Q;
                rd_req.perm_addr = jj + {7'd0, ~i1_cmp};
                rd_req.mod_addr  = ii + perm_data;
                state_next = ST_HASH1;
            end
            ST_HASH1:
            begin
                ch_next[0]       = mod_data;
                rd_req.perm_addr = jj + 8'd1;
                rd_req.mod_addr  = ii + {7'd0, i1_reg} + perm_data;
                state_next       = ST_HASH2;
            end
            ST_HASH2:
            begin
                ch_next[1]      = mod_data;
                rd_req.mod_addr = ii + 8'd1 + perm_data;
                state_next      = ST_HASH3;
            end
            ST_HASH3:
            begin
                ch_next[2] = mod_data;
                c_next     = 2'd0;
                sum_next   = '0;
                state_next = ST_SQX;
            end
            ST_SQX:
            begin
                sqx_next   = sq_prod;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                // negative falloff drops the corner
                t_next     = (falloff < 0) ? '0 : falloff[31:16];
                state_next = ST_POW2;
            end
            ST_POW2:
            begin
                t_next     = pow_prod[31:16];
                state_next = ST_POW4;
            end
            ST_POW4:
            begin
                t_next     = pow_prod[31:16];
                state_next = ST_DOT;
            end
            ST_DOT:
            begin
                sum_next = sum_reg + dot_sh[15:0];
                c_next   = c_reg + 2'd1;
                if (c_reg == 2'd2)
                    state_next = ST_NOISE;
                else
                    state_next = ST_SQX;
            end
            ST_NOISE:
            begin
                noise_next = 23'(sum_reg) * snf_pkg::NOISE_SCALE;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next   = acc_reg + snf_pkg::ACC_W'(acc_prod);
                state_next = ST_AMP;
            end
            ST_AMP:
            begin
                amp_next = amp_prod[32:16];
                if (freq_sh > {4'd0, snf_pkg::FREQ_MAX})
                    freq_next = snf_pkg::FREQ_MAX;
                else
                    freq_next = freq_sh[snf_pkg::FREQ_W-1:0];
                k_next = k_reg + 1'b1;
                if ((k_reg + 1'b1) == n_reg)
                    state_next = ST_NORM;
                else
                    state_next = ST_SCALE_X;
            end
            ST_NORM:
            begin
                if (norm_sh > 61'sd32767)
                    res_next = 16'sh7FFF;
                else if (norm_sh < -61'sd32768)
                    res_next = 16'sh8000;
                else
                    res_next = norm_sh[15:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    status.result_valid = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            c_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            c_reg     <= c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        n_reg     <= n_next;
        amp_reg   <= amp_next;
        freq_reg  <= freq_next;
        acc_reg   <= acc_next;
        xs_reg    <= xs_next;
        ys_reg    <= ys_next;
        s_reg     <= s_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        ch_reg    <= ch_next;
        i1_reg    <= i1_next;
        sqx_reg   <= sqx_next;
        t_reg     <= t_next;
        sum_reg   <= sum_next;
        noise_reg <= noise_next;
        res_reg   <= res_next;
    end

    assign result = res_reg;

endmodule

### rtl/core/simplex_noise_2d_fractal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simplex_noise_2d_fractal
// Fractal (fBm) 2D simplex noise over a loadable permutation table.
// ----------------------------------------------------------------------------
// Input beats on s_axis: tuser selects a table load (0) or an evaluation (1).
// A load writes table_value at table_index and returns nothing.
// An evaluation returns one beat on m_axis with the Q1.15 noise value.
// Each octave runs through the shared sequencer: scaling, skew and the six
// table reads, the square, power and dot steps per corner, then weighting
// and stepping; the sample is then normalized and handed to the output register.
// The table memories give one read per cycle each, setting the hashing steps.
// A new beat can be taken from the cycle after the sequencer hands off its
// result, while that result may still sit in the output register.
// Writing a config register restarts the normalizer (up to 8 sum steps and
// 32 divide steps); s_axis_tready stays low until it is done.
// Reset clears control state and loads the register defaults; the table
// holds no defined data until loaded. A stalled m_axis holds its beat and,
// once the sequencer finishes the next sample, stops further input.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module simplex_noise_2d_fractal (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] x_coord, [63:32] y_coord, [71:64] table_index, [79:72] table_value
    input  logic [79:0]                       s_axis_tdata,
    // [0] cmd
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] noise_value
    output logic [15:0]                       m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [snf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [snf_pkg::CFG_W-1:0]         cfg_data
);

    logic [snf_pkg::OCT_W-1:0]   octave_reg, octave_next;
    logic [snf_pkg::CFG_W-1:0]   persist_reg, persist_next;
    logic [snf_pkg::CFG_W-1:0]   lacun_reg, lacun_next;
    logic                        out_valid_reg, out_valid_next;
    logic [15:0]                 out_data_reg, out_data_next;

    logic                        cfg_start;
    logic                        norm_busy;
    logic [snf_pkg::NORM_W-1:0]  norm_recip;
    logic                        in_ready;
    logic                        in_beat;
    logic                        load_en;
    logic                        eval_start;
    logic                        out_free;
    snf_pkg::core_status_t       core_status;
    snf_pkg::rd_req_t            rd_req;
    logic [7:0]                  perm_data;
    logic [3:0]                  mod_data;
    logic signed [15:0]          core_result;

    always_comb
    begin
        octave_next  = octave_reg;
        persist_next = persist_reg;
        lacun_next   = lacun_reg;
        cfg_start    = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                snf_pkg::CFG_OCTAVES:
                begin
                    octave_next = cfg_data[snf_pkg::OCT_W-1:0];
                    cfg_start   = 1'b1;
                end
                snf_pkg::CFG_PERSIST:
                begin
                    persist_next = cfg_data;
                    cfg_start    = 1'b1;
                end
                snf_pkg::CFG_LACUN:
                begin
                    lacun_next = cfg_data;
                    cfg_start  = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign in_ready   = core_status.idle && !norm_busy && !cfg_we;
    assign in_beat    = s_axis_tvalid && in_ready;
    assign load_en    = in_beat && (s_axis_tuser == snf_pkg::CMD_LOAD);
    assign eval_start = in_beat && (s_axis_tuser == snf_pkg::CMD_EVAL);
    assign out_free   = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (core_status.result_valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = core_result;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_reg    <= snf_pkg::OCT_W'(1);
            persist_reg   <= 16'd32768;
            lacun_reg     <= 16'd8192;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            octave_reg    <= octave_next;
            persist_reg   <= persist_next;
            lacun_reg     <= lacun_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    snf_perm_mem u_mem (
        .clk       (clk),
        .wr_en     (load_en),
        .wr_addr   (s_axis_tdata[71:64]),
        .wr_value  (s_axis_tdata[79:72]),
        .rd_req    (rd_req),
        .perm_data (perm_data),
        .mod_data  (mod_data)
    );

    snf_norm_unit u_norm (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (cfg_start),
        .octave_count (octave_next),
        .persistence  (persist_next),
        .busy         (norm_busy),
        .norm_recip   (norm_recip)
    );

    snf_octave_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (eval_start),
        .x_coord      (s_axis_tdata[31:0]),
        .y_coord      (s_axis_tdata[63:32]),
        .octave_count (octave_reg),
        .persistence  (persist_reg),
        .lacunarity   (lacun_reg),
        .norm_recip   (norm_recip),
        .out_free     (out_free),
        .rd_req       (rd_req),
        .perm_data    (perm_data),
        .mod_data     (mod_data),
        .status       (core_status),
        .result       (core_result)
    );

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `SNF_ASSERT_IMPL(a_result_slot_free, core_status.result_valid, !out_valid_reg || m_axis_tready, "result handed off over a held beat")
    `SNF_ASSERT_NEXT(a_cfg_starts_norm, cfg_start, norm_busy, "config write did not start normalizer")
    `SNF_ASSERT_NEXT(a_eval_starts_core, eval_start, !core_status.idle, "evaluate beat did not start sequencer")

endmodule

### tb/snf_noise_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snf_noise_checker
// Watches the config port and both streams of the fractal noise block. It
// keeps its own copy of the permutation table and the registers, predicts
// the noise value of every evaluation beat, and compares each output beat
// with the oldest prediction.
// ----------------------------------------------------------------------------
module snf_noise_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [79:0]                   s_axis_tdata,
    input  logic                          s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [15:0]                   m_axis_tdata,
    input  logic                          cfg_we,
    input  logic [snf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [snf_pkg::CFG_W-1:0]     cfg_data,
    output int                            pending,
    output int                            errors,
    output int                            evals_seen,
    output int                            loads_seen
);

    localparam longint SKEW_F2   = 23987;
    localparam longint UNSKEW_G2 = 13849;
    localparam longint FREQ_CAP  = 64'h0FFF_FFFF;

    logic [7:0]  perm_copy [256];
    logic [3:0]  perm_mod12_copy [256];
    logic [3:0]  oct_reg;
    logic [15:0] persist_reg;
    logic [15:0] lacun_reg;
    longint      norm_recip;
    logic [15:0] noise_expected [$];

    function automatic int octaves_used(input logic [3:0] n);
        int r;
        r = n;
        if (r < 1)
            r = 1;
        if (r > snf_pkg::MAX_OCTAVES)
            r = snf_pkg::MAX_OCTAVES;
        return r;
    endfunction

    function automatic longint amp_recip(input logic [3:0] n, input logic [15:0] p);
        longint amp;
        longint total;
        amp = 65536;
        total = 0;
        for (int k = 0; k < octaves_used(n); k++)
        begin
            total += amp;
            amp = (amp * longint'(p)) >>> 16;
        end
        return (longint'(1) <<< 31) / total;
    endfunction

    function automatic longint corner_term(input longint dx, input longint dy,
                                           input logic [3:0] g);
        longint t;
        longint gx;
        longint gy;
        t = (longint'(1) <<< 31) - dx * dx - dy * dy;
        if (t < 0)
            return 0;
        // gradients: diagonals for hash codes 0..3, +-x for 4..7, +-y for 8..11, zero above
        gx = (g < 8) ? ((g[0]) ? -1 : 1) : 0;
        gy = (g < 4) ? ((g[1]) ? -1 : 1) : ((g >= 8 && g < 12) ? ((g[0]) ? -1 : 1) : 0);
        t = t >>> 16;
        t = (t * t) >>> 16;
        t = (t * t) >>> 16;
        return (t * (gx * dx + gy * dy)) >>> 16;
    endfunction

    function automatic longint simplex_at(input longint px, input longint py);
        longint s, i, j, t, x0, y0, i1, j1;
        logic [7:0] ii, jj;
        logic [3:0] h0, h1, h2;
        s = ((px + py) * SKEW_F2) >>> 16;
        i = (px + s) >>> 16;
        j = (py + s) >>> 16;
        t = ((i + j) * UNSKEW_G2 * 65536) >>> 16;
        x0 = px - i * 65536 + t;
        y0 = py - j * 65536 + t;
        i1 = (x0 > y0) ? 1 : 0;
        j1 = 1 - i1;
        ii = i[7:0];
        jj = j[7:0];
        h0 = perm_mod12_copy[8'(ii + perm_copy[jj])];
        h1 = perm_mod12_copy[8'(ii + i1[7:0] + perm_copy[8'(jj + j1[7:0])])];
        h2 = perm_mod12_copy[8'(ii + 8'd1 + perm_copy[8'(jj + 8'd1)])];
        return 70 * (corner_term(x0, y0, h0)
                   + corner_term(x0 - i1 * 65536 + UNSKEW_G2,
                                 y0 - j1 * 65536 + UNSKEW_G2, h1)
                   + corner_term(x0 - 65536 + 2 * UNSKEW_G2,
                                 y0 - 65536 + 2 * UNSKEW_G2, h2));
    endfunction

    function automatic longint sat_coord(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [15:0] fbm_noise(input logic signed [31:0] xc,
                                              input logic signed [31:0] yc);
        longint amp, freq, acc, r;
        amp = 65536;
        freq = 4096;
        acc = 0;
        for (int k = 0; k < octaves_used(oct_reg); k++)
        begin
            acc += simplex_at(sat_coord((longint'(xc) * freq) >>> 12),
                              sat_coord((longint'(yc) * freq) >>> 12)) * amp;
            amp = (amp * longint'(persist_reg)) >>> 16;
            freq = (freq * longint'(lacun_reg)) >>> 12;
            if (freq > FREQ_CAP)
                freq = FREQ_CAP;
        end
        r = (acc * norm_recip) >>> 32;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    assign pending = noise_expected.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_reg     <= 4'd1;
            persist_reg <= 16'd32768;
            lacun_reg   <= 16'd8192;
            norm_recip  <= 32768;
            errors      <= 0;
            evals_seen  <= 0;
            loads_seen  <= 0;
            noise_expected.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    snf_pkg::CFG_OCTAVES:
                    begin
                        oct_reg <= cfg_data[3:0];
                        norm_recip <= amp_recip(cfg_data[3:0], persist_reg);
                    end
                    snf_pkg::CFG_PERSIST:
                    begin
                        persist_reg <= cfg_data;
                        norm_recip <= amp_recip(oct_reg, cfg_data);
                    end
                    snf_pkg::CFG_LACUN:
                        lacun_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == snf_pkg::CMD_EVAL)
                begin
                    noise_expected.push_back(fbm_noise(s_axis_tdata[31:0],
                                                       s_axis_tdata[63:32]));
                    evals_seen <= evals_seen + 1;
                end
                else
                begin
                    perm_copy[s_axis_tdata[71:64]] = s_axis_tdata[79:72];
                    perm_mod12_copy[s_axis_tdata[71:64]] = 4'(s_axis_tdata[79:72] % 12);
                    loads_seen <= loads_seen + 1;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (noise_expected.size() == 0)
                begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("[%0t] unexpected output beat %h", $realtime, m_axis_tdata);
                end
                else if (noise_expected[0] !== m_axis_tdata)
                begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("[%0t] noise_value expected %0d got %0d", $realtime,
                                 $signed(noise_expected[0]), $signed(m_axis_tdata));
                    void'(noise_expected.pop_front());
                end
                else
                    void'(noise_expected.pop_front());
            end
        end
    end

endmodule

### tb/simplex_noise_2d_fractal_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simplex_noise_2d_fractal_tb
// Loads a shuffled permutation table, then drives directed and random
// evaluation and load beats under several register settings and idling
// patterns. A separate checker predicts and compares every output beat.
// ----------------------------------------------------------------------------
module simplex_noise_2d_fractal_tb;

    localparam logic [snf_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int STALL_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        s_axis_tuser = snf_pkg::CMD_LOAD;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [snf_pkg::CFG_IDX_W-1:0] cfg_index = snf_pkg::CFG_OCTAVES;
    logic [snf_pkg::CFG_W-1:0]     cfg_data = '0;

    int pending, errors, evals_seen, loads_seen;
    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int quiet_cycles = 0;
    logic [7:0] shuffle [256];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    simplex_noise_2d_fractal u_top (.*);

    snf_noise_checker u_chk (.*);

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_beat(input logic cmd, input logic [31:0] xc, input logic [31:0] yc,
                             input logic [7:0] idx, input logic [7:0] val);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {val, idx, yc, xc};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain_outputs();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(input logic [snf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [snf_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_beat();
        logic [31:0] xc, yc;
        int pick;
        pick = $urandom_range(0, 99);
        xc = $urandom();
        yc = $urandom();
        if (pick < 20)
            send_beat(snf_pkg::CMD_LOAD, xc, yc, 8'($urandom()), 8'($urandom()));
        else if (pick < 75)
            // near the origin: many triangles and table wraps
            send_beat(snf_pkg::CMD_EVAL, 32'($signed(xc) >>> $urandom_range(8, 14)),
                      32'($signed(yc) >>> $urandom_range(8, 14)), 8'($urandom()),
                      8'($urandom()));
        else
            send_beat(snf_pkg::CMD_EVAL, xc, yc, 8'($urandom()), 8'($urandom()));
    endtask

    task automatic run_phase(input logic [3:0] octs, input logic [15:0] pers,
                             input logic [15:0] lac, input int beats);
        write_reg(snf_pkg::CFG_OCTAVES, 16'(octs));
        write_reg(snf_pkg::CFG_PERSIST, pers);
        write_reg(snf_pkg::CFG_LACUN, lac);
        for (int k = 0; k < beats; k++)
            random_beat();
        drain_outputs();
    endtask

    initial
    begin
        int tmp, r;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every table entry gets written before any evaluation
        for (int k = 0; k < 256; k++)
            shuffle[k] = k[7:0];
        for (int k = 255; k > 0; k--)
        begin
            r = $urandom_range(0, k);
            tmp = shuffle[k];
            shuffle[k] = shuffle[r];
            shuffle[r] = tmp[7:0];
        end
        for (int k = 0; k < 256; k++)
            send_beat(snf_pkg::CMD_LOAD, $urandom(), $urandom(), k[7:0], shuffle[k]);

        // directed, under reset register values
        send_beat(snf_pkg::CMD_EVAL, 32'd0, 32'd0, 8'd0, 8'd0);
        send_beat(snf_pkg::CMD_EVAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0, 8'd0);
        send_beat(snf_pkg::CMD_EVAL, 32'h8000_0000, 32'h8000_0000, 8'd0, 8'd0);
        send_beat(snf_pkg::CMD_EVAL, 32'h7FFF_FFFF, 32'h8000_0000, 8'd0, 8'd0);
        send_beat(snf_pkg::CMD_EVAL, 32'h0000_8000, 32'h0000_4000, 8'd0, 8'd0);
        send_beat(snf_pkg::CMD_EVAL, 32'h0000_4000, 32'h0000_8000, 8'd0, 8'd0);
        send_beat(snf_pkg::CMD_EVAL, 32'hFFFF_8000, 32'hFFFE_C000, 8'd0, 8'd0);
        send_beat(snf_pkg::CMD_EVAL, 32'h0003_0000, 32'h0005_0000, 8'd0, 8'd0);
        send_beat(snf_pkg::CMD_EVAL, 32'h00FF_8000, 32'h00FF_C000, 8'd0, 8'd0);
        send_beat(snf_pkg::CMD_LOAD, 32'd0, 32'd0, 8'd255, 8'd0);
        send_beat(snf_pkg::CMD_LOAD, 32'd0, 32'd0, 8'd0, 8'd255);
        send_beat(snf_pkg::CMD_EVAL, 32'h00FF_1234, 32'hFFFF_0100, 8'd0, 8'd0);
        drain_outputs();

        // unmapped register index must be ignored
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        // zero octaves and an over-range count, directed
        write_reg(snf_pkg::CFG_OCTAVES, 16'd0);
        send_beat(snf_pkg::CMD_EVAL, 32'h0001_2345, 32'h0000_9876, 8'd0, 8'd0);
        drain_outputs();
        write_reg(snf_pkg::CFG_OCTAVES, 16'd15);
        send_beat(snf_pkg::CMD_EVAL, 32'h0001_2345, 32'h0000_9876, 8'd0, 8'd0);
        send_beat(snf_pkg::CMD_EVAL, 32'h7FFF_FFFF, 32'h8000_0000, 8'd0, 8'd0);
        drain_outputs();

        src_idle_pct = 33;
        dst_idle_pct = 80;
        run_phase(4'd1, 16'd32768, 16'd8192, 120);
        run_phase(4'd8, 16'hFFFF, 16'hFFFF, 40);
        src_idle_pct = 80;
        dst_idle_pct = 33;
        run_phase(4'd0, 16'd0, 16'd0, 120);
        run_phase(4'd3, 16'($urandom()), 16'($urandom()), 100);
        src_idle_pct = 0;
        dst_idle_pct = 0;
        run_phase(4'd15, 16'd40000, 16'd4096, 40);
        run_phase(4'd2, 16'($urandom()), 16'($urandom_range(4096, 12288)), 160);

        $display("Covered %0d evaluations and %0d table loads", evals_seen, loads_seen);
        $display("over octave counts 0..15, extreme persistence/lacunarity, three idling modes");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/snf_pkg.sv
rtl/core/snf_perm_mem.sv
rtl/core/snf_norm_unit.sv
rtl/core/snf_octave_core.sv
rtl/core/simplex_noise_2d_fractal.sv
tb/snf_noise_checker.sv
tb/simplex_noise_2d_fractal_tb.sv
